[sv/scrm_pkg.sv]
package scrm_pkg;

  localparam int K_MAX    = 256;
  localparam int COLS_MAX = 64;
  localparam int NNZ_MAX  = 4096;

  localparam int KW    = $clog2(K_MAX);
  localparam int CW    = $clog2(COLS_MAX);
  localparam int NW    = $clog2(NNZ_MAX);
  localparam int FILLW = NW + 1;
  localparam int CNTW  = 7;
  localparam int ACCW  = 24;
  localparam int VALW  = 8;
  localparam int PRODW = 2 * VALW;

  localparam logic [CNTW-1:0]        ROW_CNT_MAX = 7'd127;
  localparam logic signed [ACCW-1:0] ACC_HI      = 24'sd4194304;
  localparam logic signed [ACCW-1:0] ACC_LO      = -24'sd4194304;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_AENT  = 2'd1;
  localparam logic [1:0] FN_END   = 2'd2;
  localparam logic [1:0] FN_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic accept;
    logic walk_init;
    logic ent_rd;
    logic acc_rd;
    logic acc_wr;
    logic emit_rd;
    logic emit_out;
  } scrm_cmd_t;

  typedef struct packed {
    logic out_free;
    logic a_ok;
    logic walk_done;
    logic emit_last;
  } scrm_sts_t;

endpackage

[sv/sparse_csr_row_multiply_top.sv]
// Load, clear and out-of-range A items need no walk; acknowledgement registered next cycle.
// A entry: then per nonzero of the named B row one entry/accum RAM pass.
// End of row: one accumulator read per emitted value.
// A result waits in an output register; no new item is taken while it is stalled there.
// Synchronous reset clears control state, B store counts and the accumulator valid bits.
module sparse_csr_row_multiply_top import scrm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             func,
  input  logic [KW-1:0]          inner_index,
  input  logic [CW-1:0]          col_index,
  input  logic signed [VALW-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   kind,
  output logic [1:0]             status,
  output logic [15:0]            result_row,
  output logic [CW-1:0]          result_col,
  output logic signed [ACCW-1:0] result_value,
  output logic                   last,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  scrm_cmd_t cmd;
  scrm_sts_t sts;

  assign pready = 1'b1;

  scrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .sts      (sts),
    .cmd      (cmd)
  );

  scrm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .inner_index  (inner_index),
    .col_index    (col_index),
    .value        (value),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .status       (status),
    .result_row   (result_row),
    .result_col   (result_col),
    .result_value (result_value),
    .last         (last)
  );

endmodule

[sv/scrm_ram.sv]
module scrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/scrm_ctrl.sv]
module scrm_ctrl import scrm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  scrm_sts_t  sts,
  output scrm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RROW  = 3'd1;
  localparam logic [2:0] S_WCHK  = 3'd2;
  localparam logic [2:0] S_WENT  = 3'd3;
  localparam logic [2:0] S_WMAC  = 3'd4;
  localparam logic [2:0] S_EMRD  = 3'd5;
  localparam logic [2:0] S_EMOUT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = !((state == S_IDLE) && sts.out_free);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          case (func)
            FN_END:  state_next = S_EMRD;
            FN_AENT: state_next = sts.a_ok ? S_RROW : S_IDLE;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RROW: begin
        cmd.walk_init = 1'b1;
        state_next    = S_WCHK;
      end
      S_WCHK: begin
        if (sts.walk_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.ent_rd = 1'b1;
          state_next = S_WENT;
        end
      end
      S_WENT: begin
        cmd.acc_rd = 1'b1;
        state_next = S_WMAC;
      end
      S_WMAC: begin
        cmd.acc_wr = 1'b1;
        state_next = S_WCHK;
      end
      S_EMRD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMOUT;
      end
      S_EMOUT: begin
        if (sts.out_free) begin
          cmd.emit_out = 1'b1;
          state_next   = sts.emit_last ? S_IDLE : S_EMRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/scrm_dp.sv]
module scrm_dp import scrm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  scrm_cmd_t              cmd,
  output scrm_sts_t              sts,
  input  logic [1:0]             func,
  input  logic [KW-1:0]          inner_index,
  input  logic [CW-1:0]          col_index,
  input  logic signed [VALW-1:0] value,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   kind,
  output logic [1:0]             status,
  output logic [15:0]            result_row,
  output logic [CW-1:0]          result_col,
  output logic signed [ACCW-1:0] result_value,
  output logic                   last
);

  logic [8:0]       inner_size;
  logic [6:0]       out_cols;
  logic [FILLW-1:0] fill;
  logic             last_valid;
  logic [KW-1:0]    last_row;
  logic [NW-1:0]    cur_start;
  logic [CNTW-1:0]  cur_count;
  logic [K_MAX-1:0]    row_valid;
  logic [COLS_MAX-1:0] acc_valid;
  logic [15:0]      row_counter;

  logic signed [VALW-1:0]  a_val;
  logic [KW-1:0]           a_row;
  logic [NW-1:0]           w_start;
  logic [CNTW-1:0]         w_cnt;
  logic [CNTW-1:0]         w_idx;
  logic [CW-1:0]           w_col;
  logic signed [PRODW-1:0] prod;
  logic                    acc_v_q;
  logic [CW-1:0]           emit_j;

  logic                    idx_ok, col_ok, same_row, below_row;
  logic [1:0]              load_st, ack_st;
  logic                    do_load, do_clear, do_ack;
  logic [NW-1:0]           new_start;
  logic [CNTW-1:0]         new_count;
  logic [NW+CNTW-1:0]      row_rdata;
  logic [CW+VALW-1:0]      ent_rdata;
  logic signed [ACCW-1:0]  acc_rdata;
  logic [CW-1:0]           acc_raddr;
  logic signed [ACCW-1:0]  acc_old;
  logic signed [ACCW:0]    sum;
  logic signed [ACCW-1:0]  sum_sat;
  logic [6:0]              n_last;
  logic                    cfg_we;

  // Register file.
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[2] ? {25'd0, out_cols} : {23'd0, inner_size};

  // Checks for a B load, in priority order.
  assign idx_ok    = {1'b0, inner_index} < inner_size;
  assign col_ok    = {1'b0, col_index} < out_cols;
  assign same_row  = last_valid && (inner_index == last_row);
  assign below_row = last_valid && (inner_index < last_row);

  always_comb begin
    if (!idx_ok || !col_ok) begin
      load_st = ST_RANGE;
    end else if (below_row) begin
      load_st = ST_ORDER;
    end else if ((fill >= FILLW'(NNZ_MAX)) || (same_row && (cur_count >= ROW_CNT_MAX))) begin
      load_st = ST_FULL;
    end else begin
      load_st = ST_OK;
    end
    case (func)
      FN_LOAD: ack_st = load_st;
      FN_AENT: ack_st = idx_ok ? ST_OK : ST_RANGE;
      default: ack_st = ST_OK;
    endcase
  end

  assign do_load   = cmd.accept && (func == FN_LOAD) && (load_st == ST_OK);
  assign do_clear  = cmd.accept && (func == FN_CLEAR);
  assign do_ack    = cmd.accept && (func != FN_END);
  assign new_start = same_row ? cur_start : fill[NW-1:0];
  assign new_count = same_row ? cur_count + 7'd1 : 7'd1;

  // Per-row start and count; a row reads as empty unless its valid bit is set.
  scrm_ram #(.WIDTH(NW + CNTW), .DEPTH(K_MAX)) u_row_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (inner_index),
    .wdata ({new_start, new_count}),
    .re    (cmd.accept),
    .raddr (inner_index),
    .rdata (row_rdata)
  );

  scrm_ram #(.WIDTH(CW + VALW), .DEPTH(NNZ_MAX)) u_ent_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (fill[NW-1:0]),
    .wdata ({col_index, value}),
    .re    (cmd.ent_rd),
    .raddr (w_start + NW'(w_idx)),
    .rdata (ent_rdata)
  );

  assign acc_raddr = cmd.emit_rd ? emit_j : ent_rdata[CW+VALW-1:VALW];

  scrm_ram #(.WIDTH(ACCW), .DEPTH(COLS_MAX)) u_acc_ram (
    .clk   (clk),
    .we    (cmd.acc_wr),
    .waddr (w_col),
    .wdata (sum_sat),
    .re    (cmd.acc_rd || cmd.emit_rd),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  assign acc_old = acc_v_q ? acc_rdata : '0;
  assign sum     = {acc_old[ACCW-1], acc_old} + (ACCW+1)'(prod);

  always_comb begin
    if (sum > (ACCW+1)'(ACC_HI)) begin
      sum_sat = ACC_HI;
    end else if (sum < (ACCW+1)'(ACC_LO)) begin
      sum_sat = ACC_LO;
    end else begin
      sum_sat = sum[ACCW-1:0];
    end
  end

  // Emitted count is out_cols clamped to one through the column maximum.
  always_comb begin
    if (out_cols == 7'd0) begin
      n_last = 7'd0;
    end else if (out_cols > 7'(COLS_MAX)) begin
      n_last = 7'(COLS_MAX - 1);
    end else begin
      n_last = out_cols - 7'd1;
    end
  end

  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.a_ok      = idx_ok;
  assign sts.walk_done = (w_idx == w_cnt);
  assign sts.emit_last = ({1'b0, emit_j} == n_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_size  <= 9'd256;
      out_cols    <= 7'd64;
      fill        <= '0;
      last_valid  <= 1'b0;
      row_valid   <= '0;
      acc_valid   <= '0;
      row_counter <= '0;
      emit_j      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (paddr[2]) begin
          out_cols <= pwdata[6:0];
        end else begin
          inner_size <= pwdata[8:0];
        end
      end
      if (do_load) begin
        fill                   <= fill + 1'b1;
        last_valid             <= 1'b1;
        row_valid[inner_index] <= 1'b1;
      end
      if (do_clear) begin
        fill       <= '0;
        last_valid <= 1'b0;
        row_valid  <= '0;
      end
      if (cmd.acc_wr) begin
        acc_valid[w_col] <= 1'b1;
      end
      if (cmd.emit_out) begin
        if (sts.emit_last) begin
          emit_j      <= '0;
          acc_valid   <= '0;
          row_counter <= row_counter + 16'd1;
        end else begin
          emit_j <= emit_j + 1'b1;
        end
      end
      if (do_ack || cmd.emit_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      last_row  <= inner_index;
      cur_start <= new_start;
      cur_count <= new_count;
    end
    if (cmd.accept) begin
      a_val <= value;
      a_row <= inner_index;
    end
    if (cmd.walk_init) begin
      w_start <= row_rdata[NW+CNTW-1:CNTW];
      w_cnt   <= row_valid[a_row] ? row_rdata[CNTW-1:0] : '0;
      w_idx   <= '0;
    end
    if (cmd.acc_rd) begin
      w_col   <= ent_rdata[CW+VALW-1:VALW];
      acc_v_q <= acc_valid[ent_rdata[CW+VALW-1:VALW]];
      prod    <= a_val * $signed(ent_rdata[VALW-1:0]);
    end
    if (cmd.emit_rd) begin
      acc_v_q <= acc_valid[emit_j];
    end
    if (cmd.acc_wr) begin
      w_idx <= w_idx + 1'b1;
    end
    if (do_ack) begin
      kind         <= 1'b0;
      status       <= ack_st;
      result_row   <= '0;
      result_col   <= '0;
      result_value <= '0;
      last         <= 1'b1;
    end else if (cmd.emit_out) begin
      kind         <= 1'b1;
      status       <= ST_OK;
      result_row   <= row_counter;
      result_col   <= emit_j;
      result_value <= acc_old;
      last         <= sts.emit_last;
    end
  end

endmodule

[tb/sparse_csr_row_multiply_top_tb.sv]
`timescale 1ns / 100ps

module sparse_csr_row_multiply_top_tb;
  import scrm_pkg::*;

  localparam int REG_INNER  = 0;
  localparam int REG_COLS   = 1;
  localparam int CYCLE_CAP  = 3000000;
  localparam int NDIR       = 24;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             func = FN_LOAD;
  logic [KW-1:0]          inner_index = '0;
  logic [CW-1:0]          col_index = '0;
  logic signed [VALW-1:0] value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   kind;
  logic [1:0]             status;
  logic [15:0]            result_row;
  logic [CW-1:0]          result_col;
  logic signed [ACCW-1:0] result_value;
  logic                   last;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  sparse_csr_row_multiply_top dut (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic                   kind;
    logic [1:0]             status;
    logic [15:0]            row;
    logic [CW-1:0]          col;
    logic signed [ACCW-1:0] val;
    logic                   last;
  } product_t;

  typedef struct {
    bit cfg;
    int f;
    int idx;
    int col;
    int v;
    bit typed;
    int st;
  } dir_row_t;

  dir_row_t dir_tab [NDIR] = '{
    '{0, FN_END,   0,   0,  0,    0, ST_OK},
    '{0, FN_LOAD,  5,   3,  127,  1, ST_OK},
    '{0, FN_LOAD,  5,   63, -128, 1, ST_OK},
    '{0, FN_LOAD,  4,   0,  1,    1, ST_ORDER},
    '{0, FN_LOAD,  255, 0,  -1,   1, ST_OK},
    '{0, FN_LOAD,  7,   0,  1,    1, ST_ORDER},
    '{0, FN_AENT,  5,   0,  -128, 1, ST_OK},
    '{0, FN_AENT,  255, 0,  127,  1, ST_OK},
    '{0, FN_AENT,  0,   0,  1,    1, ST_OK},
    '{0, FN_END,   0,   0,  0,    0, ST_OK},
    '{0, FN_CLEAR, 255, 63, -1,   1, ST_OK},
    '{0, FN_LOAD,  0,   0,  0,    1, ST_OK},
    '{0, FN_AENT,  0,   0,  5,    1, ST_OK},
    '{0, FN_END,   0,   0,  0,    0, ST_OK},
    '{1, 0, REG_INNER,  0,  10,   0, ST_OK},
    '{1, 0, REG_COLS,   0,  1,    0, ST_OK},
    '{0, FN_LOAD,  10,  0,  1,    1, ST_RANGE},
    '{0, FN_LOAD,  3,   1,  1,    1, ST_RANGE},
    '{0, FN_AENT,  200, 0,  1,    1, ST_RANGE},
    '{0, FN_LOAD,  9,   0,  -1,   1, ST_OK},
    '{0, FN_AENT,  9,   0,  3,    1, ST_OK},
    '{0, FN_END,   0,   0,  0,    0, ST_OK},
    '{1, 0, REG_INNER,  0,  256,  0, ST_OK},
    '{1, 0, REG_COLS,   0,  64,   0, ST_OK}
  };

  // Shadow copy of the block's state.
  int unsigned     cfg_inner;
  int unsigned     cfg_cols;
  int unsigned     b_start [K_MAX];
  int unsigned     b_cnt [K_MAX];
  logic [CW-1:0]   b_col [NNZ_MAX];
  int              b_val [NNZ_MAX];
  int unsigned     b_fill;
  bit              last_ok;
  int unsigned     last_row;
  int              acc [COLS_MAX];
  logic [15:0]     row_ctr;

  product_t pending_products [$];
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       errors = 0;
  int       transfers_in = 0;
  int       transfers_out = 0;
  int       cycles = 0;

  function automatic void reset_shadow();
    cfg_inner = 256;
    cfg_cols = 64;
    b_cnt = '{default: 0};
    b_fill = 0;
    last_ok = 0;
    last_row = 0;
    acc = '{default: 0};
    row_ctr = '0;
  endfunction

  function automatic logic [1:0] store_entry(int unsigned r, int unsigned c, int v);
    bit fresh;
    if (r >= cfg_inner || r >= K_MAX || c >= cfg_cols || c >= COLS_MAX) return ST_RANGE;
    if (last_ok && r < last_row) return ST_ORDER;
    fresh = !(last_ok && r == last_row);
    if (b_fill >= NNZ_MAX || (!fresh && b_cnt[r] >= ROW_CNT_MAX)) return ST_FULL;
    if (fresh) begin
      b_start[r] = b_fill;
      b_cnt[r] = 0;
      last_row = r;
      last_ok = 1;
    end
    b_col[b_fill] = c;
    b_val[b_fill] = v;
    b_fill++;
    b_cnt[r]++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] scale_row(int unsigned k, int a);
    int s;
    int unsigned slot;
    if (k >= cfg_inner || k >= K_MAX) return ST_RANGE;
    for (int unsigned i = 0; i < b_cnt[k]; i++) begin
      slot = b_start[k] + i;
      if (slot >= NNZ_MAX) break;
      s = acc[b_col[slot]] + a * b_val[slot];
      if (s > ACC_HI) s = ACC_HI;
      if (s < ACC_LO) s = ACC_LO;
      acc[b_col[slot]] = s;
    end
    return ST_OK;
  endfunction

  function automatic void predict_products(logic [1:0] f, logic [7:0] k, logic [5:0] c,
                                           logic signed [7:0] v);
    product_t p;
    int unsigned n;
    p = '{kind: 1'b0, status: ST_OK, row: '0, col: '0, val: '0, last: 1'b1};
    case (f)
      FN_LOAD: begin
        p.status = store_entry(k, c, v);
        pending_products.push_back(p);
      end
      FN_AENT: begin
        p.status = scale_row(k, v);
        pending_products.push_back(p);
      end
      FN_CLEAR: begin
        b_cnt = '{default: 0};
        b_fill = 0;
        last_ok = 0;
        last_row = 0;
        pending_products.push_back(p);
      end
      default: begin
        n = cfg_cols;
        if (n < 1) n = 1;
        if (n > COLS_MAX) n = COLS_MAX;
        for (int unsigned j = 0; j < n; j++) begin
          p = '{kind: 1'b1, status: ST_OK, row: row_ctr, col: j, val: acc[j],
                last: (j + 1 == n)};
          pending_products.push_back(p);
        end
        acc = '{default: 0};
        row_ctr = row_ctr + 16'd1;
      end
    endcase
  endfunction

  // Drives one item and waits for its transfer; the shadow state is updated at the transfer.
  task automatic send_item(int f, int k, int c, int v, bit typed = 0, int st = 0);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f[1:0];
    inner_index <= k[7:0];
    col_index <= c[5:0];
    value <= v[7:0];
    do @(posedge clk); while (in_stall);
    transfers_in++;
    predict_products(f[1:0], k[7:0], c[5:0], v[7:0]);
    if (typed) pending_products[$].status = st[1:0];
  endtask

  // Waits for every expected result and for the block to finish its current item.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    while (in_stall) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(int r, int v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * r);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == REG_INNER) cfg_inner = v & 9'h1FF;
    else cfg_cols = v & 7'h7F;
  endtask

  task automatic send_noise();
    send_item($urandom_range(3), $urandom_range(255), $urandom_range(63), $urandom_range(255));
  endtask

  // A mostly well-formed product: clear, load B in row order, then a few A rows, with some random noise items.
  task automatic send_product(int budget, inout int sent);
    int r;
    int nb;
    int na;
    send_item(FN_CLEAR, 0, 0, 0);
    sent++;
    r = $urandom_range(0, (cfg_inner > 4) ? 3 : cfg_inner - 1);
    nb = $urandom_range(1, 12);
    for (int i = 0; i < nb && sent < budget; i++) begin
      if ($urandom_range(99) < 8) send_noise();
      else send_item(FN_LOAD, r, $urandom_range(0, cfg_cols - 1), $urandom_range(255));
      sent++;
      r = r + $urandom_range(0, 2);
      if (r > int'(cfg_inner) - 1) r = cfg_inner - 1;
    end
    for (int row = 0; row < $urandom_range(1, 3) && sent < budget; row++) begin
      na = $urandom_range(0, 4);
      for (int i = 0; i < na; i++) begin
        if ($urandom_range(99) < 8) send_noise();
        else send_item(FN_AENT, $urandom_range(0, cfg_inner - 1), $urandom_range(63),
                       $urandom_range(255));
        sent++;
      end
      send_item(FN_END, $urandom_range(255), $urandom_range(63), $urandom_range(255));
      sent++;
    end
  endtask

  task automatic run_phase(int iv, int sv, int inner, int cols, int budget, bit pause);
    int sent;
    sent = 0;
    write_reg(REG_INNER, inner);
    write_reg(REG_COLS, cols);
    idle_pct = iv;
    stall_pct = sv;
    while (sent < budget) begin
      send_product(budget, sent);
      if (pause && sent > budget / 2) begin
        drain();
        pause = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    product_t e;
    if (!rst && out_valid && !out_stall) begin
      transfers_out++;
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected result kind=%0d status=%0d row=%0d col=%0d value=%0d last=%0d",
                 $time, kind, status, result_row, result_col, result_value, last);
        errors++;
      end else begin
        e = pending_products.pop_front();
        if (kind !== e.kind || status !== e.status || result_row !== e.row ||
            result_col !== e.col || result_value !== e.val || last !== e.last) begin
          $display("%0t: mismatch expected kind=%0d status=%0d row=%0d col=%0d value=%0d last=%0d",
                   $time, e.kind, e.status, e.row, e.col, e.val, e.last);
          $display("%0t:          actual   kind=%0d status=%0d row=%0d col=%0d value=%0d last=%0d",
                   $time, kind, status, result_row, result_col, result_value, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("sparse_csr_row_multiply_top regression: fail");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg) write_reg(dir_tab[i].idx, dir_tab[i].v);
      else send_item(dir_tab[i].f, dir_tab[i].idx, dir_tab[i].col, dir_tab[i].v,
                     dir_tab[i].typed, dir_tab[i].st);
    end

    // One B row filled to its entry limit, all into column 0, then driven into saturation.
    send_item(FN_CLEAR, 0, 0, 0, 1, ST_OK);
    for (int i = 0; i < 127; i++) send_item(FN_LOAD, 0, 0, -128);
    send_item(FN_LOAD, 0, 1, 1, 1, ST_FULL);
    send_item(FN_AENT, 0, 0, -128);
    send_item(FN_AENT, 0, 0, -128);
    send_item(FN_END, 0, 0, 0);
    for (int i = 0; i < 5; i++) send_item(FN_AENT, 0, 0, 127);
    send_item(FN_END, 0, 0, 0);

    run_phase(0, 0, 256, 64, 66, 0);
    run_phase(53, 0, $urandom_range(1, 16), $urandom_range(1, 64), 66, 1);
    run_phase(0, 53, 1, 1, 66, 0);
    run_phase(37, 37, $urandom_range(2, 256), 64, 66, 0);

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d input transfers and %0d result transfers: loads, A entries,",
             transfers_in, transfers_out);
    $display("row ends, clears, range and order errors, the row entry limit and saturation.");
    if (errors == 0 && pending_products.size() == 0)
      $display("sparse_csr_row_multiply_top regression: pass");
    else
      $display("sparse_csr_row_multiply_top regression: fail");
    $finish;
  end

endmodule
